/* rtl/core/tmt_pkg.sv */
// shared types and constants of the trimmed mean tachometer
package tmt_pkg;

    localparam int unsigned CNT_W   = 16;
    localparam int unsigned SCALE_W = 8;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd30;
    localparam logic [CNT_W-1:0]   MIN_INIT    = 16'hFFFF;

    typedef struct packed {
        logic [CNT_W-1:0] counter_snapshot;
        logic             delay_load;
        logic [CNT_W-1:0] delay_value;
    } tmt_tick_t;

    typedef struct packed {
        logic [CNT_W-1:0] speed;
        logic             fan_off;
    } tmt_result_t;

    // one history sample arriving from the memory read port
    typedef struct packed {
        logic valid;
        logic first;
    } tmt_smp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TRIM,
        ST_DIV,
        ST_MUL
    } tmt_state_t;

endpackage

/* rtl/core/tmt_trim.sv */
// running difference statistics over the history walk: sum, largest and smallest
module tmt_trim (
    input  logic                      clk,
    input  tmt_pkg::tmt_smp_t         smp,
    input  logic [tmt_pkg::CNT_W-1:0] sample,
    output logic [tmt_pkg::CNT_W-1:0] diff_sum,
    output logic [tmt_pkg::CNT_W-1:0] diff_max,
    output logic [tmt_pkg::CNT_W-1:0] diff_min
);
    import tmt_pkg::*;

    logic [CNT_W-1:0] prev_reg;
    logic [CNT_W-1:0] sum_reg;
    logic [CNT_W-1:0] max_reg;
    logic [CNT_W-1:0] min_reg;
    logic [CNT_W-1:0] diff;

    // counter difference, wraps modulo 2^16
    assign diff = sample - prev_reg;

    always_ff @(posedge clk)
    begin
        if (smp.valid)
        begin
            prev_reg <= sample;
            if (smp.first)
            begin
                sum_reg <= '0;
                max_reg <= '0;
                min_reg <= MIN_INIT;
            end
            else
            begin
                sum_reg <= sum_reg + diff;
                if (diff > max_reg)
                begin
                    max_reg <= diff;
                end
                if (diff < min_reg)
                begin
                    min_reg <= diff;
                end
            end
        end
    end

    assign diff_sum = sum_reg;
    assign diff_max = max_reg;
    assign diff_min = min_reg;

endmodule

/* rtl/core/trimmed_mean_tachometer_unit.sv */
// Trimmed mean tachometer: each tick transfer stores the counter snapshot in a history
// memory of HISTORY_DEPTH entries, walks it from oldest to newest one read per cycle,
// sums the consecutive differences, drops the largest and smallest, divides by
// HISTORY_DEPTH-3 through a constant reciprocal multiply and scales by scale_reg. The next
// tick transfer is taken only after the walk, paced by the single read port of the history
// memory, and the trim, divide and multiply steps; a finished result waits in the output
// register while the next tick is processed. History entries
// read as zero until written (per-entry valid bits cleared by reset, no clearing pass).
// The shut-off countdown is loaded and decremented in the cycle of the tick transfer.
module trimmed_mean_tachometer_unit #(
    parameter int HISTORY_DEPTH = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick_valid,
    output logic                        tick_stall,
    input  tmt_pkg::tmt_tick_t          tick,
    output logic                        result_valid,
    input  logic                        result_stall,
    output tmt_pkg::tmt_result_t        result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tmt_pkg::SCALE_W-1:0] cfg_data
);
    import tmt_pkg::*;

    localparam int PTR_W     = $clog2(HISTORY_DEPTH);
    localparam int IDX_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int DIVISOR   = HISTORY_DEPTH - 3;
    localparam int DIV_SHIFT = CNT_W + $clog2(DIVISOR);
    localparam int RECIP     = ((1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = CNT_W + RECIP_W;
    localparam int SPD_W     = CNT_W + SCALE_W;

    tmt_state_t state_reg, state_next;

    logic [CNT_W-1:0]         hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_ok_reg;

    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_vld_reg;
    logic               rd_first_reg;
    logic               rd_last_reg;
    logic [CNT_W-1:0]   rd_data_reg;
    logic               rd_ok_reg;
    logic               rd_issue;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_dec;
    logic               fan_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic [CNT_W-1:0]   mean_reg;
    logic [CNT_W-1:0]   quot_reg;
    logic [PROD_W-1:0]  quot_prod;
    logic [SPD_W-1:0]   spd_prod;

    logic               res_vld_reg;
    tmt_result_t        res_reg;
    logic               tick_xfer;
    logic               out_free;
    logic               res_load;

    tmt_smp_t           smp;
    logic [CNT_W-1:0]   sample;
    logic [CNT_W-1:0]   diff_sum;
    logic [CNT_W-1:0]   diff_max;
    logic [CNT_W-1:0]   diff_min;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign tick_xfer = tick_valid && !tick_stall;
    assign out_free  = !res_vld_reg || !result_stall;
    assign rd_issue  = (state_reg == ST_READ) && (rd_idx_reg != IDX_W'(HISTORY_DEPTH));
    assign cnt_dec   = (tick.delay_load ? tick.delay_value : cnt_reg) - 1'b1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tick_stall = 1'b1;
        res_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick_stall = 1'b0;
                if (tick_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (rd_last_reg)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // history memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            hist_mem[wr_ptr_reg] <= tick.counter_snapshot;
        end
        rd_data_reg <= hist_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_ok_reg  <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
            cnt_reg      <= '0;
            fan_reg      <= 1'b0;
            scale_reg    <= SCALE_RESET;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= rd_issue;
            rd_first_reg <= rd_issue && (rd_idx_reg == '0);
            rd_last_reg  <= rd_issue && (rd_idx_reg == IDX_W'(HISTORY_DEPTH - 1));
            rd_ok_reg    <= hist_ok_reg[rd_ptr_reg];
            if (tick_xfer)
            begin
                hist_ok_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg <= next_slot(wr_ptr_reg);
                // walk starts at the oldest entry, the one after the newest
                rd_ptr_reg <= next_slot(wr_ptr_reg);
                rd_idx_reg <= '0;
                cnt_reg    <= cnt_dec;
                fan_reg    <= (cnt_dec == '0);
            end
            else if (rd_issue)
            begin
                rd_ptr_reg <= next_slot(rd_ptr_reg);
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= cfg_data;
            end
            if (res_load)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    assign smp.valid = rd_vld_reg;
    assign smp.first = rd_first_reg;
    assign sample    = rd_ok_reg ? rd_data_reg : '0;

    tmt_trim u_trim (
        .clk      (clk),
        .smp      (smp),
        .sample   (sample),
        .diff_sum (diff_sum),
        .diff_max (diff_max),
        .diff_min (diff_min)
    );

    // divide by a constant through a rounded-up reciprocal, exact for 16-bit values
    assign quot_prod = PROD_W'(mean_reg) * PROD_W'(RECIP);
    assign spd_prod  = SPD_W'(quot_reg) * SPD_W'(scale_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TRIM)
        begin
            mean_reg <= diff_sum - diff_max - diff_min;
        end
        if (state_reg == ST_DIV)
        begin
            quot_reg <= quot_prod[DIV_SHIFT +: CNT_W];
        end
        if (res_load)
        begin
            res_reg.speed   <= spd_prod[CNT_W-1:0];
            res_reg.fan_off <= fan_reg;
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

/* rtl/core/tmt_checker.sv */
// port-level checks of the trimmed mean tachometer and their binding
module tmt_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 tick_valid,
    input logic                 tick_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input tmt_pkg::tmt_result_t result
);

    // one tick in flight: the input side is held off right after a transfer
    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> tick_stall ##1 tick_stall)
        else $error("tick taken while the previous one is in work");

    // a new result only appears at the end of a tick's work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(tick_stall))
        else $error("result appeared without a tick in work");

    // no result is shown in the cycle right after a tick transfer unless it was waiting
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall && !result_valid) |=> !result_valid)
        else $error("result appeared too early");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind trimmed_mean_tachometer_unit tmt_checker u_tmt_checker (.*);

/* dv/tb_trimmed_mean_tachometer_unit.sv */
`timescale 1ns / 100ps
// testbench of the trimmed mean tachometer unit: directed and random ticks checked against a predictor
module tb_trimmed_mean_tachometer_unit;
    import tmt_pkg::*;

    localparam int DEPTH       = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 2 * (DEPTH + 5);
    localparam int PHASE_TICKS = 250;
    localparam int NUM_PHASES  = 6;

    logic                clk;
    logic                rst_n;
    logic                tick_valid;
    logic                tick_stall;
    tmt_tick_t           tick;
    logic                result_valid;
    logic                result_stall;
    tmt_result_t         result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SCALE_W-1:0]  cfg_data;

    // predictor state
    logic [CNT_W-1:0]    snap_hist [DEPTH];
    int unsigned         next_slot_idx;
    logic [CNT_W-1:0]    shutoff_count;
    logic [SCALE_W-1:0]  speed_scale;
    tmt_result_t         readings_due [$];
    tmt_result_t         due_reading;

    int                  errors;
    int                  cycle_count;
    bit                  idle_on;
    int                  long_hold;
    int                  stall_left;
    logic [CNT_W-1:0]    rev_count;

    trimmed_mean_tachometer_unit #(
        .HISTORY_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[trimmed_mean_tachometer_unit] ERROR");
        $finish;
    end

    // speed and fan-off flag that one tick produces; advances the predictor state
    function automatic tmt_result_t next_reading(input tmt_tick_t t);
        logic [CNT_W-1:0]   prv;
        logic [CNT_W-1:0]   cur;
        logic [CNT_W-1:0]   d;
        logic [CNT_W-1:0]   sum;
        logic [CNT_W-1:0]   big;
        logic [CNT_W-1:0]   lo;
        logic [CNT_W-1:0]   mean;
        logic [2*CNT_W-1:0] prod;
        int unsigned        p;
        tmt_result_t        r;
        snap_hist[next_slot_idx] = t.counter_snapshot;
        next_slot_idx = (next_slot_idx + 1) % DEPTH;
        // slot after the newest write holds the oldest snapshot
        p = next_slot_idx;
        cur = snap_hist[p];
        sum = '0;
        big = '0;
        lo = '1;
        for (int n = 1; n < DEPTH; n++)
        begin
            prv = cur;
            p = (p + 1) % DEPTH;
            cur = snap_hist[p];
            d = cur - prv;
            if (d > big)
                big = d;
            if (d < lo)
                lo = d;
            sum = sum + d;
        end
        mean = sum - big - lo;
        mean = mean / CNT_W'(DEPTH - 3);
        prod = mean * speed_scale;
        r.speed = prod[CNT_W-1:0];
        if (t.delay_load)
            shutoff_count = t.delay_value;
        shutoff_count = shutoff_count - 1'b1;
        r.fan_off = (shutoff_count == '0);
        return r;
    endfunction

    function automatic tmt_tick_t mk_tick(input logic [CNT_W-1:0] snap, input logic load,
                                          input logic [CNT_W-1:0] dval);
        tmt_tick_t t;
        t.counter_snapshot = snap;
        t.delay_load = load;
        t.delay_value = dval;
        return t;
    endfunction

    // mostly a running counter with random speed, now and then a glitch sample
    function automatic tmt_tick_t random_tick();
        tmt_tick_t   t;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            t.counter_snapshot = CNT_W'($urandom);
        else
        begin
            if (pick == 1)
                rev_count = rev_count + CNT_W'($urandom);
            else if (pick != 2)
                rev_count = rev_count + CNT_W'($urandom_range(1, 3000));
            t.counter_snapshot = rev_count;
        end
        t.delay_load = ($urandom_range(0, 19) == 0);
        if (t.delay_load && $urandom_range(0, 3) != 0)
            t.delay_value = CNT_W'($urandom_range(0, 40));
        else
            t.delay_value = CNT_W'($urandom);
        return t;
    endfunction

    task automatic send_tick(input tmt_tick_t t);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick <= t;
        do
            @(posedge clk);
        while (tick_stall);
        readings_due.push_back(next_reading(t));
    endtask

    task automatic wait_drain();
        tick_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        speed_scale = v;
    endtask

    // receiver side: random stall bursts, or one long hold-off on request
    initial
    begin
        stall_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                long_hold--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (readings_due.size() == 0)
            begin
                $display("%0t unexpected result: speed %h fan_off %b", $time,
                         result.speed, result.fan_off);
                errors++;
            end
            else
            begin
                due_reading = readings_due.pop_front();
                if (result.speed !== due_reading.speed)
                begin
                    $display("%0t speed mismatch: expected %h actual %h", $time,
                             due_reading.speed, result.speed);
                    errors++;
                end
                if (result.fan_off !== due_reading.fan_off)
                begin
                    $display("%0t fan_off mismatch: expected %b actual %b", $time,
                             due_reading.fan_off, result.fan_off);
                    errors++;
                end
            end
        end
    end

    // zero history from reset takes part; countdown at zero wraps without a flag
    task automatic test_unfilled_history();
        send_tick(mk_tick(16'd100, 1'b0, 16'hA5A5));
        send_tick(mk_tick(16'd250, 1'b0, 16'h5A5A));
        send_tick(mk_tick(16'd400, 1'b0, 16'h0000));
        send_tick(mk_tick(16'd1000, 1'b0, 16'hFFFF));
    endtask

    // snapshot extremes and counter wrap across zero
    task automatic test_counter_extremes();
        send_tick(mk_tick(16'hFFFF, 1'b0, 16'hFFFF));
        send_tick(mk_tick(16'h0000, 1'b0, 16'h0000));
        send_tick(mk_tick(16'hFFF0, 1'b0, 16'hFFFF));
        send_tick(mk_tick(16'h0010, 1'b0, 16'h0000));
        send_tick(mk_tick(16'h8000, 1'b0, 16'hFFFF));
        send_tick(mk_tick(16'hFFFF, 1'b0, 16'h0000));
        send_tick(mk_tick(16'h0000, 1'b0, 16'h1234));
    endtask

    // load of one flags at once, load of zero wraps, a short countdown runs out
    task automatic test_countdown_edges();
        send_tick(mk_tick(16'h0100, 1'b1, 16'd1));
        send_tick(mk_tick(16'h0200, 1'b1, 16'd0));
        send_tick(mk_tick(16'h0300, 1'b1, 16'hFFFF));
        send_tick(mk_tick(16'h0400, 1'b1, 16'd3));
        send_tick(mk_tick(16'h0500, 1'b0, 16'd7));
        send_tick(mk_tick(16'h0600, 1'b0, 16'd9));
    endtask

    task automatic test_scale_extremes();
        write_scale(8'd0);
        send_tick(mk_tick(16'h0700, 1'b0, 16'd0));
        send_tick(mk_tick(16'h0900, 1'b0, 16'd0));
        write_scale(8'd255);
        send_tick(mk_tick(16'h0C00, 1'b0, 16'd0));
        send_tick(mk_tick(16'h1000, 1'b0, 16'd0));
        write_scale(8'd1);
        send_tick(mk_tick(16'h1500, 1'b0, 16'd0));
        send_tick(mk_tick(16'h1B00, 1'b0, 16'd0));
    endtask

    // output held off long enough that the unit fills up and stalls its input
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        long_hold = 300;
        repeat (30) send_tick(random_tick());
        wait_drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_ticks();
        logic [SCALE_W-1:0] scale_val;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: scale_val = 8'd1;
                1: scale_val = 8'd255;
                3: scale_val = SCALE_RESET;
                default: scale_val = SCALE_W'($urandom_range(0, 255));
            endcase
            write_scale(scale_val);
            if (ph == NUM_PHASES - 1)
                idle_on = 1'b0;
            repeat (PHASE_TICKS) send_tick(random_tick());
        end
    endtask

    initial
    begin
        errors = 0;
        idle_on = 1'b1;
        long_hold = 0;
        rev_count = '0;
        rst_n = 1'b0;
        tick_valid = 1'b0;
        tick = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < DEPTH; i++)
            snap_hist[i] = '0;
        next_slot_idx = 0;
        shutoff_count = '0;
        speed_scale = SCALE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unfilled_history();
        test_counter_extremes();
        test_countdown_edges();
        test_scale_extremes();
        test_output_backpressure();
        test_random_ticks();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && readings_due.size() == 0)
            $display("[trimmed_mean_tachometer_unit] OK");
        else
            $display("[trimmed_mean_tachometer_unit] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tmt_pkg.sv
rtl/core/tmt_trim.sv
rtl/core/trimmed_mean_tachometer_unit.sv
rtl/core/tmt_checker.sv
dv/tb_trimmed_mean_tachometer_unit.sv
